// File: rtl/rc4_pkg.sv
// ---------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher engine.
// ---------------------------------------------------------------------------
package rc4_pkg;

    localparam int PERM_SIZE = 256;
    localparam int IDX_W     = $clog2(PERM_SIZE);
    localparam int KEY_W     = 64;
    localparam int KLEN_W    = 5;
    localparam int PADDR_W   = 5;

    localparam logic [KLEN_W-1:0] KEY_LEN_MAX   = 5'd16;
    localparam logic [KLEN_W-1:0] KEY_LEN_MIN   = 5'd1;
    localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 5'd16;

    localparam logic [1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic FUNC_KEY   = 1'b0;
    localparam logic FUNC_CRYPT = 1'b1;

    localparam logic KIND_KEYED = 1'b0;
    localparam logic KIND_CRYPT = 1'b1;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } sbox_wr_t;

endpackage

// File: rtl/rc4_ram.sv
// ---------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ---------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: rtl/rc4_sbox.sv
// ---------------------------------------------------------------------------
// rc4_sbox
// Permutation store: RAM plus per-entry valid bits. An entry that has not
// been written since reset or the last clear reads as its own address.
// ---------------------------------------------------------------------------
module rc4_sbox
    import rc4_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic [IDX_W-1:0] rd_addr,
    input  sbox_wr_t         wr,
    output logic [IDX_W-1:0] rd_data
);

    logic [PERM_SIZE-1:0] valid_reg;
    logic                 q_valid_reg;
    logic [IDX_W-1:0]     q_addr_reg;
    logic [IDX_W-1:0]     ram_q;

    rc4_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PERM_SIZE)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= valid_reg[rd_addr];
            if (clr) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_addr_reg <= rd_addr;
    end

    assign rd_data = q_valid_reg ? ram_q : q_addr_reg;

endmodule

// File: rtl/rc4_stream_cipher.sv
// ---------------------------------------------------------------------------
// rc4_stream_cipher
// Crypt transaction: dependent S-box reads on the single RAM read port run
// through CR1, CR2, CR3 to result valid; CR3 holds while the output stalls
// and no new byte is taken until IDLE. Key schedule: KA, KB, KC per keyed
// swap (read S[n], read S[j], write), then KFIN writes the last entry.
// Reset: synchronous, active low; S-box reads as identity right away through
// valid bits, indices clear, key registers clear, key length goes to 16.
// ---------------------------------------------------------------------------
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [KEY_W-1:0]   pwdata,
    output logic [KEY_W-1:0]   prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [7:0]         s_data_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_kind
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_CR1  = 8'b0000_0010,
        ST_CR2  = 8'b0000_0100,
        ST_CR3  = 8'b0000_1000,
        ST_KA   = 8'b0001_0000,
        ST_KB   = 8'b0010_0000,
        ST_KC   = 8'b0100_0000,
        ST_KFIN = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [KEY_W-1:0]   key_low_reg, key_high_reg;
    logic [KLEN_W-1:0]  key_length_reg;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [3:0]         kpos_reg, kpos_next;
    logic [IDX_W-1:0]   si_reg, si_next;
    logic [IDX_W-1:0]   sj_reg, sj_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [7:0]         data_reg, data_next;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_kind_reg, out_kind_next;

    logic               out_free;
    logic               out_load;
    logic               cfg_wr;
    logic               sb_clr;
    logic [IDX_W-1:0]   sb_rd_addr;
    logic [IDX_W-1:0]   sb_q;
    sbox_wr_t           sb_wr;
    logic [KLEN_W-1:0]  eff_len;
    logic [7:0]         key_byte;
    logic [IDX_W-1:0]   ks_byte;

    rc4_sbox u_sbox (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (sb_clr),
        .rd_addr (sb_rd_addr),
        .wr      (sb_wr),
        .rd_data (sb_q)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_LEN_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_KEY_LOW:    key_low_reg    <= pwdata;
                REG_KEY_HIGH:   key_high_reg   <= pwdata;
                REG_KEY_LENGTH: key_length_reg <= pwdata[KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_KEY_LOW:    prdata = key_low_reg;
            REG_KEY_HIGH:   prdata = key_high_reg;
            REG_KEY_LENGTH: prdata = {{(KEY_W-KLEN_W){1'b0}}, key_length_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (key_length_reg < KEY_LEN_MIN) begin
            eff_len = KEY_LEN_MIN;
        end else if (key_length_reg > KEY_LEN_MAX) begin
            eff_len = KEY_LEN_MAX;
        end else begin
            eff_len = key_length_reg;
        end
    end

    assign key_byte = kpos_reg[3] ? key_high_reg[{kpos_reg[2:0], 3'b000} +: 8]
                                  : key_low_reg[{kpos_reg[2:0], 3'b000} +: 8];

    // keystream byte, forwarded past the swap writes still in flight
    always_comb begin
        if (t_reg == j_reg) begin
            ks_byte = si_reg;
        end else if (t_reg == i_reg) begin
            ks_byte = sj_reg;
        end else begin
            ks_byte = sb_q;
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        kpos_next     = kpos_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        data_next     = data_reg;
        out_byte_next = out_byte_reg;
        out_kind_next = out_kind_reg;
        out_load      = 1'b0;
        sb_clr        = 1'b0;
        sb_rd_addr    = t_reg;
        sb_wr         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_CRYPT) begin
                        i_next     = i_reg + 8'd1;
                        sb_rd_addr = i_reg + 8'd1;
                        data_next  = s_data_byte;
                        state_next = ST_CR1;
                    end else begin
                        sb_clr     = 1'b1;
                        n_next     = '0;
                        kpos_next  = '0;
                        j_next     = '0;
                        state_next = ST_KA;
                    end
                end
            end
            ST_CR1: begin
                si_next    = sb_q;
                j_next     = j_reg + sb_q;
                sb_rd_addr = j_reg + sb_q;
                state_next = ST_CR2;
            end
            ST_CR2: begin
                sj_next    = sb_q;
                sb_wr.en   = 1'b1;
                sb_wr.addr = i_reg;
                sb_wr.data = sb_q;
                t_next     = si_reg + sb_q;
                sb_rd_addr = si_reg + sb_q;
                state_next = ST_CR3;
            end
            ST_CR3: begin
                sb_wr.en   = 1'b1;
                sb_wr.addr = j_reg;
                sb_wr.data = si_reg;
                sb_rd_addr = t_reg;
                if (out_free) begin
                    out_load      = 1'b1;
                    out_byte_next = data_reg ^ ks_byte;
                    out_kind_next = KIND_CRYPT;
                    state_next    = ST_IDLE;
                end
            end
            ST_KA: begin
                sb_rd_addr = n_reg;
                if (n_reg != '0) begin
                    sb_wr.en   = 1'b1;
                    sb_wr.addr = n_reg - 8'd1;
                    sb_wr.data = sj_reg;
                end
                state_next = ST_KB;
            end
            ST_KB: begin
                si_next    = sb_q;
                j_next     = j_reg + sb_q + key_byte;
                sb_rd_addr = j_reg + sb_q + key_byte;
                state_next = ST_KC;
            end
            ST_KC: begin
                sj_next    = sb_q;
                sb_wr.en   = 1'b1;
                sb_wr.addr = j_reg;
                sb_wr.data = si_reg;
                if (({1'b0, kpos_reg} + 5'd1) >= eff_len) begin
                    kpos_next = '0;
                end else begin
                    kpos_next = kpos_reg + 4'd1;
                end
                if (&n_reg) begin
                    state_next = ST_KFIN;
                end else begin
                    n_next     = n_reg + 8'd1;
                    state_next = ST_KA;
                end
            end
            ST_KFIN: begin
                sb_wr.en   = 1'b1;
                sb_wr.addr = n_reg;
                sb_wr.data = sj_reg;
                if (out_free) begin
                    out_load      = 1'b1;
                    out_byte_next = '0;
                    out_kind_next = KIND_KEYED;
                    i_next        = '0;
                    j_next        = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            kpos_reg  <= kpos_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_kind     = out_kind_reg;

    a_key_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_KEY)) |=> (state_reg == ST_KA))
        else $error("key schedule did not start");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid ##1 m_valid) |-> $past(state_reg == ST_CR3 || state_reg == ST_KFIN))
        else $error("result appeared outside a finishing state");

    a_keyed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_KEYED)) |-> (m_out_byte == 8'd0))
        else $error("key schedule result is not zero");

    a_idx_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KFIN && out_free) |=> (i_reg == '0 && j_reg == '0))
        else $error("indices not cleared after key schedule");

    a_ks_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KC && !(&n_reg)) |=> (state_reg == ST_KA && !s_ready))
        else $error("key schedule loop broken");

endmodule

// File: tb/tb_rc4_stream_cipher.sv
// ---------------------------------------------------------------------------
// tb_rc4_stream_cipher
// Self-checking testbench for the RC4 stream cipher engine. A software copy
// of the permutation, indices and key registers predicts every result; the
// block's results are compared field by field in order of acceptance. Covers
// crypt on the reset state, key schedules over saturated key lengths and
// extreme keys, then random key setups with random byte streams under
// random idling on both channels and one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
    import rc4_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int WATCHDOG_LIMIT  = 6000;
    localparam int HOLD_OFF_AT     = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 66;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
    } cipher_result_t;

    class arcfour_tracker;
        logic [7:0]     sbox [PERM_SIZE];
        logic [7:0]     idx_i;
        logic [7:0]     idx_j;
        logic [63:0]    key_lo;
        logic [63:0]    key_hi;
        logic [4:0]     key_len;
        cipher_result_t pending_bytes [$];
        int             errors;

        function new();
            for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'(n);
            idx_i   = '0;
            idx_j   = '0;
            key_lo  = '0;
            key_hi  = '0;
            key_len = KEY_LEN_RESET;
            errors  = 0;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_KEY_LOW:    key_lo  = value;
                REG_KEY_HIGH:   key_hi  = value;
                REG_KEY_LENGTH: key_len = value[4:0];
                default: ;
            endcase
        endfunction

        function void run_key_schedule();
            int         len;
            int         kpos;
            logic [7:0] acc;
            logic [7:0] kb;
            logic [7:0] t;
            len = int'(key_len);
            if (len < int'(KEY_LEN_MIN)) len = int'(KEY_LEN_MIN);
            if (len > int'(KEY_LEN_MAX)) len = int'(KEY_LEN_MAX);
            kpos = 0;
            acc  = '0;
            for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'(n);
            for (int n = 0; n < PERM_SIZE; n++) begin
                kb = (kpos < 8) ? key_lo[kpos*8 +: 8] : key_hi[(kpos-8)*8 +: 8];
                acc = acc + sbox[n] + kb;
                t = sbox[acc];
                sbox[acc] = sbox[n];
                sbox[n] = t;
                kpos++;
                if (kpos >= len) kpos = 0;
            end
            idx_i = '0;
            idx_j = '0;
        endfunction

        function logic [7:0] crypt(logic [7:0] data);
            logic [7:0] t;
            logic [7:0] sum;
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox[idx_i];
            t = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = t;
            sum = sbox[idx_i] + sbox[idx_j];
            return data ^ sbox[sum];
        endfunction

        function void note_request(logic func, logic [7:0] data);
            cipher_result_t r;
            if (func == FUNC_KEY) begin
                run_key_schedule();
                r.out_byte = 8'h00;
                r.kind     = KIND_KEYED;
            end else begin
                r.out_byte = crypt(data);
                r.kind     = KIND_CRYPT;
            end
            pending_bytes.push_back(r);
        endfunction

        function void check_response(logic [7:0] out_byte, logic kind);
            cipher_result_t want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: out_byte %0h kind %0b", out_byte, kind);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0b, actual %0b", want.kind, kind);
                errors++;
            end
            if (out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [KEY_W-1:0]   pwdata;
    logic [KEY_W-1:0]   prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [7:0]         s_data_byte;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_out_byte;
    logic               m_kind;

    arcfour_tracker tracker;
    bit             no_idle;
    int             results_seen;
    int             idle_cycles;

    rc4_stream_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_kind      (m_kind)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD/2) aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_item(input logic func, input logic [7:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_func      = func;
        s_data_byte = data;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(func, data);
        @(negedge aclk);
    endtask

    // all results in before touching the key registers
    task automatic wait_drained();
        s_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [63:0] len);
        wait_drained();
        apb_write(REG_KEY_LOW, lo);
        apb_write(REG_KEY_HIGH, hi);
        apb_write(REG_KEY_LENGTH, len);
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if ((n == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 39) == 0)
                send_item(FUNC_KEY, 8'($urandom_range(0, 255)));
            else
                send_item(FUNC_CRYPT, 8'($urandom_range(0, 255)));
        end
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = draw_gap();
            if (results_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            tracker.check_response(m_out_byte, m_kind);
            results_seen++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] len_value;
        tracker      = new();
        no_idle      = 1'b0;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_func       = FUNC_KEY;
        s_data_byte  = '0;
        m_ready      = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // crypt on the reset permutation, then a key schedule on reset keys
        send_item(FUNC_CRYPT, 8'h00);
        send_item(FUNC_CRYPT, 8'hFF);
        send_item(FUNC_CRYPT, 8'h3C);
        send_item(FUNC_KEY, 8'hA5);
        send_item(FUNC_CRYPT, 8'h00);
        send_item(FUNC_CRYPT, 8'hFF);

        set_key('1, '1, 64'(KEY_LEN_MAX));
        send_item(FUNC_KEY, 8'hFF);
        send_item(FUNC_CRYPT, 8'h00);
        send_item(FUNC_CRYPT, 8'hFF);

        // zero length saturates up to one byte
        wait_drained();
        apb_write(REG_KEY_LENGTH, 64'd0);
        send_item(FUNC_KEY, 8'h00);
        send_item(FUNC_CRYPT, 8'hAA);

        set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'(KEY_LEN_MIN));
        send_item(FUNC_KEY, 8'h00);
        send_item(FUNC_CRYPT, 8'h55);

        // lengths above sixteen saturate down
        wait_drained();
        apb_write(REG_KEY_LENGTH, 64'd17);
        send_item(FUNC_KEY, 8'h00);
        send_item(FUNC_CRYPT, 8'h0F);

        wait_drained();
        apb_write(REG_KEY_LENGTH, 64'd31);
        send_item(FUNC_KEY, 8'h00);
        send_item(FUNC_CRYPT, 8'hF0);

        // upper write bits beyond the length field, and a write past the map
        wait_drained();
        apb_write(REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFE8);
        apb_write(REG_UNUSED, '1);
        send_item(FUNC_KEY, 8'h00);
        send_item(FUNC_CRYPT, 8'h81);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(0, 3) == 0)
                len_value = 64'($urandom_range(0, 31));
            else
                len_value = 64'($urandom_range(1, 16));
            set_key({$urandom(), $urandom()}, {$urandom(), $urandom()}, len_value);
            no_idle = ($urandom_range(0, 3) == 0);
            random_phase(PHASE_ITEMS);
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_sbox.sv
rtl/rc4_stream_cipher.sv
tb/tb_rc4_stream_cipher.sv
